// ===== rtl/wqac_pkg.sv =====
// ============================================================================
// wqac_pkg
// Shared types, level codes and reading grader for the water quality alarm
// controller.
// ============================================================================
package wqac_pkg;

    localparam int TIME_W  = 32;
    localparam int PH_W    = 11;
    localparam int TDS_W   = 16;
    localparam int HARD_W  = 16;
    localparam int LEVEL_W = 2;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [LEVEL_W-1:0] LVL_SAFE    = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_CAUTION = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_WARNING = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_DANGER  = 2'd3;

    localparam logic ACT_CHECK  = 1'b0;
    localparam logic ACT_BUZZER = 1'b1;

    localparam logic [1:0] REG_STARTUP = 2'd0;
    localparam logic [1:0] REG_STABLE  = 2'd1;
    localparam logic [1:0] REG_DANGER  = 2'd2;
    localparam logic [1:0] REG_ROUTINE = 2'd3;

    localparam logic [TIME_W-1:0] WARN_PERIOD_MS    = 32'd250;
    localparam logic [TIME_W-1:0] CAUTION_PERIOD_MS = 32'd1000;

    localparam logic [TDS_W-1:0]  TDS_DANGER   = 16'd16000;
    localparam logic [TDS_W-1:0]  TDS_WARNING  = 16'd5000;
    localparam logic [TDS_W-1:0]  TDS_CAUTION  = 16'd4000;
    localparam logic [HARD_W-1:0] HARD_DANGER  = 16'd6000;
    localparam logic [HARD_W-1:0] HARD_WARNING = 16'd2000;
    localparam logic [HARD_W-1:0] HARD_CAUTION = 16'd1500;
    localparam logic [PH_W-1:0]   PH_DANGER_LO  = 11'd600;
    localparam logic [PH_W-1:0]   PH_DANGER_HI  = 11'd900;
    localparam logic [PH_W-1:0]   PH_WARNING_LO = 11'd650;
    localparam logic [PH_W-1:0]   PH_WARNING_HI = 11'd850;
    localparam logic [PH_W-1:0]   PH_CAUTION_LO = 11'd680;
    localparam logic [PH_W-1:0]   PH_CAUTION_HI = 11'd820;

    typedef struct packed {
        logic [TIME_W-1:0] startup_delay_ms;
        logic [TIME_W-1:0] stabilize_ms;
        logic [TIME_W-1:0] danger_repeat_ms;
        logic [TIME_W-1:0] routine_repeat_ms;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic               active;
        logic [LEVEL_W-1:0] grade;
        logic [TIME_W-1:0]  now_ms;
        logic [PH_W-1:0]    ph;
        logic [TDS_W-1:0]   tds;
        logic [HARD_W-1:0]  hard;
    } item_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_stat_t;

    function automatic logic [LEVEL_W-1:0] lvl_max(
        input logic [LEVEL_W-1:0] a,
        input logic [LEVEL_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic [LEVEL_W-1:0] grade_f(
        input logic [PH_W-1:0]   ph,
        input logic [TDS_W-1:0]  tds,
        input logic [HARD_W-1:0] hard
    );
        logic [LEVEL_W-1:0] g_tds;
        logic [LEVEL_W-1:0] g_hard;
        logic [LEVEL_W-1:0] g_ph;
        if (tds > TDS_DANGER)       g_tds = LVL_DANGER;
        else if (tds > TDS_WARNING) g_tds = LVL_WARNING;
        else if (tds > TDS_CAUTION) g_tds = LVL_CAUTION;
        else                        g_tds = LVL_SAFE;
        if (hard > HARD_DANGER)       g_hard = LVL_DANGER;
        else if (hard > HARD_WARNING) g_hard = LVL_WARNING;
        else if (hard > HARD_CAUTION) g_hard = LVL_CAUTION;
        else                          g_hard = LVL_SAFE;
        if (ph < PH_DANGER_LO || ph > PH_DANGER_HI)        g_ph = LVL_DANGER;
        else if (ph < PH_WARNING_LO || ph > PH_WARNING_HI) g_ph = LVL_WARNING;
        else if (ph < PH_CAUTION_LO || ph > PH_CAUTION_HI) g_ph = LVL_CAUTION;
        else                                               g_ph = LVL_SAFE;
        return lvl_max(lvl_max(g_tds, g_hard), g_ph);
    endfunction

endpackage

// ===== rtl/water_quality_alarm_controller.sv =====
// ============================================================================
// water_quality_alarm_controller
// Grades water readings into alarm levels, debounces the level, raises
// notification pulses and drives the buzzer pattern.
// ============================================================================
//  port group   direction  handshake          contents
//  s_*          in         s_valid/s_ready    action, time, pH, TDS, hardness
//  m_*          out        m_valid/m_ready    level, notify, buzzer, readings
//  apb          in/out     psel/penable       four 32-bit timing registers
//
//  One request per cycle while m_ready does not stall; each request passes
//  through a queue entry, then the result register, before it reaches m_*.
//  The state engine update is combinational feedback through the level registers.
//  Synchronous active-low reset clears the control state and loads register defaults.
//  A stalled m_ready fills the queue, then drops s_ready.
// ============================================================================
module water_quality_alarm_controller import wqac_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [TIME_W-1:0]  s_now_ms,
    input  logic [PH_W-1:0]    s_ph_hundredths,
    input  logic [TDS_W-1:0]   s_tds_tenths,
    input  logic [HARD_W-1:0]  s_hardness_tenths,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_level,
    output logic               m_notify,
    output logic               m_buzzer_on,
    output logic [PH_W-1:0]    m_report_ph,
    output logic [TDS_W-1:0]   m_report_tds,
    output logic [HARD_W-1:0]  m_report_hardness,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t        cfg_reg;
    logic        q_push;
    logic        q_pop;
    item_t       push_item;
    item_t       head_item;
    queue_stat_t q_stat;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.startup_delay_ms  <= 32'd10000;
            cfg_reg.stabilize_ms      <= 32'd5000;
            cfg_reg.danger_repeat_ms  <= 32'd60000;
            cfg_reg.routine_repeat_ms <= 32'd3600000;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_STARTUP: cfg_reg.startup_delay_ms  <= pwdata;
                REG_STABLE:  cfg_reg.stabilize_ms      <= pwdata;
                REG_DANGER:  cfg_reg.danger_repeat_ms  <= pwdata;
                REG_ROUTINE: cfg_reg.routine_repeat_ms <= pwdata;
                default:     cfg_reg.startup_delay_ms  <= cfg_reg.startup_delay_ms;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STARTUP: prdata = cfg_reg.startup_delay_ms;
            REG_STABLE:  prdata = cfg_reg.stabilize_ms;
            REG_DANGER:  prdata = cfg_reg.danger_repeat_ms;
            REG_ROUTINE: prdata = cfg_reg.routine_repeat_ms;
            default:     prdata = '0;
        endcase
    end

    wqac_front u_front (
        .cfg               (cfg_reg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_now_ms          (s_now_ms),
        .s_ph_hundredths   (s_ph_hundredths),
        .s_tds_tenths      (s_tds_tenths),
        .s_hardness_tenths (s_hardness_tenths),
        .q_full            (q_stat.full),
        .q_push            (q_push),
        .q_item            (push_item)
    );

    wqac_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    wqac_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_empty           (q_stat.empty),
        .q_item            (head_item),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_level           (m_level),
        .m_notify          (m_notify),
        .m_buzzer_on       (m_buzzer_on),
        .m_report_ph       (m_report_ph),
        .m_report_tds      (m_report_tds),
        .m_report_hardness (m_report_hardness)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_stat.full)
        else $error("input stalled while queue has room");

    a_push_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.push && !q_stat.pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
        else $error("queue count missed a push");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.pop |=> m_valid)
        else $error("popped request produced no result");

endmodule

// ===== rtl/wqac_front.sv =====
// ============================================================================
// wqac_front
// Accepts input requests, grades the readings and flags the startup window.
// ============================================================================
module wqac_front import wqac_pkg::*; (
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [TIME_W-1:0]  s_now_ms,
    input  logic [PH_W-1:0]    s_ph_hundredths,
    input  logic [TDS_W-1:0]   s_tds_tenths,
    input  logic [HARD_W-1:0]  s_hardness_tenths,
    input  logic               q_full,
    output logic               q_push,
    output item_t              q_item
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.action = s_action;
        q_item.active = (s_now_ms >= cfg.startup_delay_ms);
        q_item.grade  = grade_f(s_ph_hundredths, s_tds_tenths, s_hardness_tenths);
        q_item.now_ms = s_now_ms;
        q_item.ph     = s_ph_hundredths;
        q_item.tds    = s_tds_tenths;
        q_item.hard   = s_hardness_tenths;
    end

endmodule

// ===== rtl/wqac_queue.sv =====
// ============================================================================
// wqac_queue
// Two-entry request queue between the classifier and the state engine.
// ============================================================================
module wqac_queue import wqac_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  item_t       push_item,
    input  logic        pop,
    output item_t       head_item,
    output queue_stat_t stat
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push   = push && (count_reg != QCNT_W'(QDEPTH));
    assign do_pop    = pop && (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_comb begin
        stat.push  = do_push;
        stat.pop   = do_pop;
        stat.full  = (count_reg == QCNT_W'(QDEPTH));
        stat.empty = (count_reg == '0);
        stat.count = count_reg;
    end

endmodule

// ===== rtl/wqac_back.sv =====
// ============================================================================
// wqac_back
// Level, notification and buzzer state engine with the result register.
// ============================================================================
module wqac_back import wqac_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_level,
    output logic               m_notify,
    output logic               m_buzzer_on,
    output logic [PH_W-1:0]    m_report_ph,
    output logic [TDS_W-1:0]   m_report_tds,
    output logic [HARD_W-1:0]  m_report_hardness
);

    logic [LEVEL_W-1:0] cand_reg,     cand_next;
    logic [TIME_W-1:0]  since_reg,    since_next;
    logic [LEVEL_W-1:0] cur_reg,      cur_next;
    logic [LEVEL_W-1:0] notified_reg, notified_next;
    logic [TIME_W-1:0]  last_ntf_reg, last_ntf_next;
    logic [TIME_W-1:0]  last_tgl_reg, last_tgl_next;
    logic               buzz_reg,     buzz_next;
    logic               notify_next;
    logic               out_valid_reg;

    logic [LEVEL_W-1:0] c_cand;
    logic [TIME_W-1:0]  c_since;
    logic [LEVEL_W-1:0] c_cur;
    logic [TIME_W-1:0]  interval;
    logic [TIME_W-1:0]  period;
    logic               is_check;
    logic               is_buzz;

    assign q_pop    = !q_empty && (!out_valid_reg || m_ready);
    assign is_check = q_pop && (q_item.action == ACT_CHECK) && q_item.active;
    assign is_buzz  = q_pop && (q_item.action == ACT_BUZZER);

    always_comb begin
        c_cand  = cand_reg;
        c_since = since_reg;
        if (q_item.grade != cand_reg) begin
            c_cand  = q_item.grade;
            c_since = q_item.now_ms;
        end
        c_cur    = ((q_item.now_ms - c_since) >= cfg.stabilize_ms) ? c_cand : cur_reg;
        interval = (c_cur == LVL_DANGER) ? cfg.danger_repeat_ms : cfg.routine_repeat_ms;

        cand_next     = cand_reg;
        since_next    = since_reg;
        cur_next      = cur_reg;
        notified_next = notified_reg;
        last_ntf_next = last_ntf_reg;
        notify_next   = 1'b0;
        if (is_check) begin
            cand_next  = c_cand;
            since_next = c_since;
            cur_next   = c_cur;
            if (c_cur > notified_reg) begin
                notify_next   = 1'b1;
                notified_next = c_cur;
                last_ntf_next = q_item.now_ms;
            end else if ((q_item.now_ms - last_ntf_reg) >= interval) begin
                notify_next   = 1'b1;
                last_ntf_next = q_item.now_ms;
            end else if (c_cur < notified_reg) begin
                notified_next = c_cur;
            end
        end
    end

    always_comb begin
        buzz_next     = buzz_reg;
        last_tgl_next = last_tgl_reg;
        period        = '0;
        case (cur_reg)
            LVL_SAFE:    buzz_next = 1'b0;
            LVL_DANGER:  buzz_next = 1'b1;
            LVL_WARNING: period    = WARN_PERIOD_MS;
            LVL_CAUTION: period    = CAUTION_PERIOD_MS;
            default:     period    = '0;
        endcase
        if (period != '0 && (q_item.now_ms - last_tgl_reg) >= period) begin
            last_tgl_next = q_item.now_ms;
            buzz_next     = !buzz_reg;
        end
        if (!is_buzz) begin
            buzz_next     = buzz_reg;
            last_tgl_next = last_tgl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg      <= LVL_SAFE;
            since_reg     <= '0;
            cur_reg       <= LVL_SAFE;
            notified_reg  <= LVL_SAFE;
            last_ntf_reg  <= '0;
            last_tgl_reg  <= '0;
            buzz_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cand_reg     <= cand_next;
            since_reg    <= since_next;
            cur_reg      <= cur_next;
            notified_reg <= notified_next;
            last_ntf_reg <= last_ntf_next;
            last_tgl_reg <= last_tgl_next;
            buzz_reg     <= buzz_next;
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_level           <= cur_next;
            m_notify          <= notify_next;
            m_buzzer_on       <= buzz_next;
            m_report_ph       <= q_item.ph;
            m_report_tds      <= q_item.tds;
            m_report_hardness <= q_item.hard;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the water quality alarm controller. A clocked
// driver feeds requests from a queue, a clocked monitor checks every result
// against an in-bench prediction of levels, notifications, buzzer drive and readings.
// Runs directed corner requests, then randomized grade runs over several
// register settings with both sides idling and one long receiver hold.
// ============================================================================
module tb_top;
    import wqac_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic               action;
        logic [TIME_W-1:0]  now_ms;
        logic [PH_W-1:0]    ph;
        logic [TDS_W-1:0]   tds;
        logic [HARD_W-1:0]  hard;
    } wq_req_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               notify;
        logic               buzzer_on;
        logic [PH_W-1:0]    ph;
        logic [TDS_W-1:0]   tds;
        logic [HARD_W-1:0]  hard;
    } wq_outcome_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = ACT_CHECK;
    logic [TIME_W-1:0]  s_now_ms = '0;
    logic [PH_W-1:0]    s_ph_hundredths = '0;
    logic [TDS_W-1:0]   s_tds_tenths = '0;
    logic [HARD_W-1:0]  s_hardness_tenths = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [LEVEL_W-1:0] m_level;
    logic               m_notify;
    logic               m_buzzer_on;
    logic [PH_W-1:0]    m_report_ph;
    logic [TDS_W-1:0]   m_report_tds;
    logic [HARD_W-1:0]  m_report_hardness;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [3:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    water_quality_alarm_controller DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_now_ms          (s_now_ms),
        .s_ph_hundredths   (s_ph_hundredths),
        .s_tds_tenths      (s_tds_tenths),
        .s_hardness_tenths (s_hardness_tenths),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_level           (m_level),
        .m_notify          (m_notify),
        .m_buzzer_on       (m_buzzer_on),
        .m_report_ph       (m_report_ph),
        .m_report_tds      (m_report_tds),
        .m_report_hardness (m_report_hardness),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #6 aclk = ~aclk;

    // bench copy of the timing registers
    logic [TIME_W-1:0] cfg_startup = 32'd10000;
    logic [TIME_W-1:0] cfg_stable  = 32'd5000;
    logic [TIME_W-1:0] cfg_danger  = 32'd60000;
    logic [TIME_W-1:0] cfg_routine = 32'd3600000;

    // bench copy of the alarm state
    logic [LEVEL_W-1:0] cand_lvl       = LVL_SAFE;
    logic [TIME_W-1:0]  cand_since     = '0;
    logic [LEVEL_W-1:0] cur_lvl        = LVL_SAFE;
    logic [LEVEL_W-1:0] sent_lvl       = LVL_SAFE;
    logic [TIME_W-1:0]  last_sent_ms   = '0;
    logic [TIME_W-1:0]  last_toggle_ms = '0;
    logic               buzz           = 1'b0;

    wq_req_t     pending_reqs[$];
    wq_outcome_t expected_outcomes[$];
    wq_req_t     live_req;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int n_accepted   = 0;
    int n_checked    = 0;
    int n_notify     = 0;
    int n_errors     = 0;
    int n_phases     = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    int hold_wait    = 0;
    bit hold_go      = 1'b0;
    bit hold_done    = 1'b0;

    function automatic logic [LEVEL_W-1:0] grade_reading(
        input logic [PH_W-1:0]   ph,
        input logic [TDS_W-1:0]  tds,
        input logic [HARD_W-1:0] hard
    );
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] s;
        g = (tds > 16000) ? LVL_DANGER  :
            (tds > 5000)  ? LVL_WARNING :
            (tds > 4000)  ? LVL_CAUTION : LVL_SAFE;
        s = (hard > 6000) ? LVL_DANGER  :
            (hard > 2000) ? LVL_WARNING :
            (hard > 1500) ? LVL_CAUTION : LVL_SAFE;
        if (s > g) g = s;
        s = (ph < 600 || ph > 900) ? LVL_DANGER  :
            (ph < 650 || ph > 850) ? LVL_WARNING :
            (ph < 680 || ph > 820) ? LVL_CAUTION : LVL_SAFE;
        if (s > g) g = s;
        return g;
    endfunction

    task automatic predict_outcome(input wq_req_t r);
        wq_outcome_t       e;
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] since;
        e.notify = 1'b0;
        if (r.action == ACT_CHECK) begin
            if (r.now_ms >= cfg_startup) begin
                if (grade_reading(r.ph, r.tds, r.hard) != cand_lvl) begin
                    cand_lvl   = grade_reading(r.ph, r.tds, r.hard);
                    cand_since = r.now_ms;
                end
                since = r.now_ms - cand_since;
                if (since >= cfg_stable) cur_lvl = cand_lvl;
                interval = (cur_lvl == LVL_DANGER) ? cfg_danger : cfg_routine;
                since = r.now_ms - last_sent_ms;
                if (cur_lvl > sent_lvl) begin
                    e.notify     = 1'b1;
                    sent_lvl     = cur_lvl;
                    last_sent_ms = r.now_ms;
                end else if (since >= interval) begin
                    e.notify     = 1'b1;
                    last_sent_ms = r.now_ms;
                end else if (cur_lvl < sent_lvl) begin
                    sent_lvl = cur_lvl;
                end
            end
        end else begin
            period = '0;
            if (cur_lvl == LVL_SAFE) buzz = 1'b0;
            else if (cur_lvl == LVL_DANGER) buzz = 1'b1;
            else period = (cur_lvl == LVL_WARNING) ? 32'd250 : 32'd1000;
            since = r.now_ms - last_toggle_ms;
            if (period != 0 && since >= period) begin
                last_toggle_ms = r.now_ms;
                buzz           = ~buzz;
            end
        end
        e.level     = cur_lvl;
        e.buzzer_on = buzz;
        e.ph        = r.ph;
        e.tds       = r.tds;
        e.hard      = r.hard;
        expected_outcomes.push_back(e);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, n_checked, got, want);
        n_errors++;
    endtask

    // driver: hold the request until accepted, then advance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_outcome(live_req);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    live_req          = pending_reqs.pop_front();
                    s_valid           <= 1'b1;
                    s_action          <= live_req.action;
                    s_now_ms          <= live_req.now_ms;
                    s_ph_hundredths   <= live_req.ph;
                    s_tds_tenths      <= live_req.tds;
                    s_hardness_tenths <= live_req.hard;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result against the oldest prediction
    always @(posedge aclk) begin
        wq_outcome_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_checked++;
                if (m_notify) n_notify++;
                if (hold_go && !hold_done) hold_wait++;
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    e = expected_outcomes.pop_front();
                    if (m_level !== e.level)
                        report_mismatch("level", 32'(m_level), 32'(e.level));
                    if (m_notify !== e.notify)
                        report_mismatch("notify", 32'(m_notify), 32'(e.notify));
                    if (m_buzzer_on !== e.buzzer_on)
                        report_mismatch("buzzer_on", 32'(m_buzzer_on), 32'(e.buzzer_on));
                    if (m_report_ph !== e.ph)
                        report_mismatch("report_ph", 32'(m_report_ph), 32'(e.ph));
                    if (m_report_tds !== e.tds)
                        report_mismatch("report_tds", 32'(m_report_tds), 32'(e.tds));
                    if (m_report_hardness !== e.hard)
                        report_mismatch("report_hardness", 32'(m_report_hardness),
                                        32'(e.hard));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_go && !hold_done && hold_wait >= 150) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic act, input logic [TIME_W-1:0] t,
                            input logic [PH_W-1:0] ph, input logic [TDS_W-1:0] tds,
                            input logic [HARD_W-1:0] hard);
        wq_req_t r;
        r.action = act;
        r.now_ms = t;
        r.ph     = ph;
        r.tds    = tds;
        r.hard   = hard;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [TDS_W-1:0] tds_for(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            LVL_SAFE:    return TDS_W'($urandom_range(4000, 0));
            LVL_CAUTION: return TDS_W'($urandom_range(5000, 4001));
            LVL_WARNING: return TDS_W'($urandom_range(16000, 5001));
            default:     return TDS_W'($urandom_range(65535, 16001));
        endcase
    endfunction

    function automatic logic [HARD_W-1:0] hard_for(input logic [LEVEL_W-1:0] lvl);
        case (lvl)
            LVL_SAFE:    return HARD_W'($urandom_range(1500, 0));
            LVL_CAUTION: return HARD_W'($urandom_range(2000, 1501));
            LVL_WARNING: return HARD_W'($urandom_range(6000, 2001));
            default:     return HARD_W'($urandom_range(65535, 6001));
        endcase
    endfunction

    function automatic logic [PH_W-1:0] ph_for(input logic [LEVEL_W-1:0] lvl);
        bit hi;
        hi = 1'($urandom_range(1, 0));
        case (lvl)
            LVL_SAFE:    return PH_W'($urandom_range(820, 680));
            LVL_CAUTION: return PH_W'(hi ? $urandom_range(850, 821) : $urandom_range(679, 650));
            LVL_WARNING: return PH_W'(hi ? $urandom_range(900, 851) : $urandom_range(649, 600));
            default:     return PH_W'(hi ? $urandom_range(2047, 901) : $urandom_range(599, 0));
        endcase
    endfunction

    // runs of a steady grade with buzzer ticks mixed in, plus some noise
    task automatic queue_random(input int n, input logic [TIME_W-1:0] t0, input int step_max);
        logic [TIME_W-1:0]  t;
        logic [LEVEL_W-1:0] target;
        logic [LEVEL_W-1:0] lower;
        int                 left;
        int                 run;
        int                 lead;
        t    = t0;
        left = n;
        while (left > 0) begin
            target = LEVEL_W'($urandom_range(3, 0));
            run    = $urandom_range(12, 3);
            for (int k = 0; k < run && left > 0; k++) begin
                if ($urandom_range(99) < 8) begin
                    t = t + $urandom_range(1 << 20, 0);
                    push_req(1'($urandom_range(1, 0)), t, PH_W'($urandom_range(2047, 0)),
                             TDS_W'($urandom_range(65535, 0)),
                             HARD_W'($urandom_range(65535, 0)));
                end else begin
                    t = t + $urandom_range(step_max, 0);
                    if ($urandom_range(99) < 35) begin
                        push_req(ACT_BUZZER, t, PH_W'($urandom_range(2047, 0)),
                                 TDS_W'($urandom_range(65535, 0)),
                                 HARD_W'($urandom_range(65535, 0)));
                    end else begin
                        lead  = $urandom_range(2, 0);
                        lower = LEVEL_W'($urandom_range(target, 0));
                        push_req(ACT_CHECK, t,
                                 ph_for(lead == 0 ? target : lower),
                                 tds_for(lead == 1 ? target
                                                   : LEVEL_W'($urandom_range(target, 0))),
                                 hard_for(lead == 2 ? target
                                                    : LEVEL_W'($urandom_range(target, 0))));
                    end
                end
                left--;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STARTUP: cfg_startup = val;
            REG_STABLE:  cfg_stable  = val;
            REG_DANGER:  cfg_danger  = val;
            REG_ROUTINE: cfg_routine = val;
            default:     ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_valid || expected_outcomes.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [31:0] startup, input logic [31:0] stable,
                             input logic [31:0] danger, input logic [31:0] routine,
                             input int n, input logic [TIME_W-1:0] t0, input int step_max);
        write_reg(REG_STARTUP, startup);
        write_reg(REG_STABLE, stable);
        write_reg(REG_DANGER, danger);
        write_reg(REG_ROUTINE, routine);
        queue_random(n, t0, step_max);
        wait_drained();
        n_phases++;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 9;
        snk_idle_pct = 79;

        // reset register values, startup window, debounce, level fall, buzzer patterns
        push_req(ACT_CHECK,  32'd0,        11'd0,    16'd65535, 16'd65535);
        push_req(ACT_BUZZER, 32'd0,        11'd2047, 16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd9999,     11'd2047, 16'd65535, 16'd65535);
        push_req(ACT_CHECK,  32'd10000,    11'd700,  16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd10000,    11'd2047, 16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd15000,    11'd1400, 16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd15100,    11'd0,    16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd20000,    11'd899,  16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd20010,    11'd0,    16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd25000,    11'd899,  16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd25000,    11'd0,    16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd25100,    11'd0,    16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd25250,    11'd0,    16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd25300,    11'd660,  16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd30300,    11'd660,  16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd30300,    11'd0,    16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd31299,    11'd0,    16'd0,     16'd0);
        push_req(ACT_BUZZER, 32'd31300,    11'd0,    16'd0,     16'd0);
        push_req(ACT_CHECK,  32'd75000,    11'd700,  16'd16001, 16'd0);
        push_req(ACT_CHECK,  32'd80000,    11'd700,  16'd16001, 16'd0);
        push_req(ACT_CHECK,  32'd140000,   11'd700,  16'd16001, 16'd0);
        push_req(ACT_CHECK,  32'd140001,   11'd850,  16'd5000,  16'd2000);
        push_req(ACT_CHECK,  32'd140002,   11'd600,  16'd16000, 16'd6000);
        push_req(ACT_CHECK,  32'd140003,   11'd820,  16'd4001,  16'd1501);
        push_req(ACT_CHECK,  32'hFFFF_FFFF, 11'd0,   16'd0,     16'd6001);
        wait_drained();

        run_phase(32'd1000, 32'd300, 32'd800, 32'd5000, 400, 32'd0, 400);

        src_idle_pct = 79;
        snk_idle_pct = 9;
        run_phase(32'd0, 32'd0, 32'd0, 32'd0, 150, 32'h8000_0000, 50);
        run_phase(32'hFFFF_FFFF, 32'd2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  80, 32'hFFFF_FF80, 5);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_go      = 1'b1;
        run_phase(32'd0, 32'd1500, 32'd2500, 32'd9000, 600, 32'hFFFE_0000, 1200);
        run_phase(32'd10000, 32'd5000, 32'd60000, 32'd3600000, 120, 32'd0, 8000);

        repeat (8) @(posedge aclk);
        $display("covered %0d requests and %0d checked results over %0d register settings",
                 n_accepted, n_checked, n_phases + 1);
        $display("%0d notify pulses seen, one %0d-cycle output hold applied, %0d mismatches",
                 n_notify, HOLD_CYCLES, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
